FILE: sv/htm_pkg.sv
// shared types, codes and defaults for the handle table manager
// no dependencies; used by every module of the block
package htm_pkg;

   // default number of slots in the table
   localparam int TABLE_SLOTS_DEF = 64;

   // free-slot search works on groups of this many flags
   localparam int GRP_W    = 64;
   localparam int GRP_BITS = 6;

   // field widths
   localparam int ID_W      = 32;
   localparam int INDEX_W   = 16;
   localparam int REQ_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ACTIVATE   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INVALIDATE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_VALIDATE   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_ACQUIRE    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_RELEASE    = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ERR  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // register indexes
   localparam logic CSR_ID_START     = 1'b0;
   localparam logic CSR_EMPTY_MARKER = 1'b1;

   // register reset values
   localparam logic [ID_W-1:0] ID_START_RST     = 32'd1;
   localparam logic [ID_W-1:0] EMPTY_MARKER_RST = 32'd0;

   // one table entry
   typedef struct packed {
      logic            lock;
      logic [ID_W-1:0] id;
   } slot_type;

endpackage

FILE: sv/htm_slot_mem.sv
// slot memory: lock bit and id per slot, one write and one read port
// read data registered; uses htm_pkg
module htm_slot_mem #(
   parameter int DEPTH  = htm_pkg::TABLE_SLOTS_DEF,
   parameter int ADDR_W = $clog2(htm_pkg::TABLE_SLOTS_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  htm_pkg::slot_type wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output htm_pkg::slot_type rd_data
);

   htm_pkg::slot_type mem_ff [DEPTH];
   htm_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/htm_free_map.sv
// free flag per slot and the two-step lowest-free-slot search
// group summary picked on load, slot within group picked next cycle; uses htm_pkg
module htm_free_map #(
   parameter int DEPTH  = htm_pkg::TABLE_SLOTS_DEF,
   parameter int ADDR_W = $clog2(htm_pkg::TABLE_SLOTS_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              upd_en,
   input  logic [ADDR_W-1:0] upd_addr,
   input  logic              upd_val,
   input  logic              grp_load,
   output logic              found,
   output logic [ADDR_W-1:0] pick
);

   localparam int NGRP  = (DEPTH + htm_pkg::GRP_W - 1) / htm_pkg::GRP_W;
   localparam int NPAD  = NGRP * htm_pkg::GRP_W;
   localparam int GB    = (NGRP > 1) ? $clog2(NGRP) : 1;

   logic [DEPTH-1:0]            free_ff;
   logic [NPAD-1:0]             free_pad;
   logic [NGRP-1:0]             grp_any;
   logic [GB-1:0]               grp_pick;
   logic [GB-1:0]               grp_ff;
   logic                        found_ff;
   logic [htm_pkg::GRP_W-1:0]   word;
   logic [htm_pkg::GRP_BITS-1:0] slot_sel;
   logic [GB+htm_pkg::GRP_BITS-1:0] pick_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
      end else if (upd_en) begin
         free_ff[upd_addr] <= upd_val;
      end
   end

   assign free_pad = NPAD'(free_ff);

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any[g] = |free_pad[g*htm_pkg::GRP_W +: htm_pkg::GRP_W];
      end
   end

   // lowest group holding a free slot
   always_comb begin
      grp_pick = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_pick = GB'(g);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_load) begin
         grp_ff   <= grp_pick;
         found_ff <= |grp_any;
      end
   end

   // lowest free slot within the chosen group
   assign word = free_pad[grp_ff*htm_pkg::GRP_W +: htm_pkg::GRP_W];

   always_comb begin
      slot_sel = '0;
      for (int i = htm_pkg::GRP_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            slot_sel = htm_pkg::GRP_BITS'(i);
         end
      end
   end

   assign pick_full = {grp_ff, slot_sel};
   assign pick      = pick_full[ADDR_W-1:0];
   assign found     = found_ff;

endmodule

FILE: sv/handle_table_manager.sv
// handle table manager top level: request sequencer, registers, result register
// depends on htm_pkg, htm_slot_mem and htm_free_map
//
// Keeps a table of TABLE_SLOTS slots, each an id and a lock bit, in one synchronous
// memory, plus a free flag per slot in flip-flops. A slot is free while its id equals
// empty_marker. For each request item the accept cycle picks the lowest group with a
// free slot, the next cycle picks the slot within that group and reads the slot
// memory, and the execute state then checks the handle, writes the slot back and
// loads the result register once that register is free. Items are handled one at a
// time; a new item is taken in the cycle after the previous one finishes, even while
// its result still waits on rsp_tready. After reset a clearing pass empties the
// table; after every write of empty_marker a rescan rebuilds the free flags. No items
// are accepted during either pass; configuration writes are always taken (csr_ready
// is tied high). Writing id_start also reloads the id counter.
module handle_table_manager #(
   parameter int TABLE_SLOTS = htm_pkg::TABLE_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_type [2:0], handle_index [18:3], handle_id [50:19], zero [55:51]
   input  logic [htm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], new_id [33:2], slot_index [49:34], zero [55:50]
   output logic [htm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [htm_pkg::ID_W-1:0]        csr_data
);

   localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W  = ADDR_W + 1;

   // sequencer states
   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,   // clearing pass after reset
      S_RSCAN = 5'b00010,   // free flag rebuild after marker change
      S_IDLE  = 5'b00100,
      S_FIND  = 5'b01000,   // slot pick and memory read
      S_EXEC  = 5'b10000    // check, write back, result
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            rescan_ff, rescan_in;
   logic [htm_pkg::ID_W-1:0]        counter_ff, counter_in;
   logic [htm_pkg::ID_W-1:0]        marker_ff, marker_in;

   // latched request
   logic [htm_pkg::REQ_W-1:0]       req_type_ff;
   logic [htm_pkg::INDEX_W-1:0]     idx_ff;
   logic [htm_pkg::ID_W-1:0]        hid_ff;
   logic [ADDR_W-1:0]               addr_ff;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [htm_pkg::RSP_DATA_W-1:0]  rsp_data_ff;

   logic req_fire, csr_fire, out_free, exec_fire;

   // memory and free map hookup
   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   htm_pkg::slot_type mem_wr_data, slot;
   logic              upd_en, upd_val;
   logic [ADDR_W-1:0] upd_addr;
   logic              found;
   logic [ADDR_W-1:0] pick;

   // execute stage results
   logic                           in_range, match;
   logic                           ex_wr, ex_free_upd, ex_free_val;
   htm_pkg::slot_type              ex_slot;
   logic [htm_pkg::STATUS_W-1:0]   ex_status;
   logic [htm_pkg::ID_W-1:0]       ex_nid;
   logic [htm_pkg::INDEX_W-1:0]    ex_sidx;
   logic [htm_pkg::ID_W-1:0]       nid_next;

   htm_slot_mem #(
      .DEPTH  (TABLE_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (slot)
   );

   htm_free_map #(
      .DEPTH  (TABLE_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_free (
      .clock    (clock),
      .reset    (reset),
      .upd_en   (upd_en),
      .upd_addr (upd_addr),
      .upd_val  (upd_val),
      .grp_load (req_fire),
      .found    (found),
      .pick     (pick)
   );

   // handshakes
   assign req_tready = (state_ff == S_IDLE) && !rescan_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign exec_fire  = (state_ff == S_EXEC) && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // handle check on the slot read back
   assign in_range = {1'b0, idx_ff} < (htm_pkg::INDEX_W + 1)'(TABLE_SLOTS);
   assign match    = in_range && (slot.id == hid_ff);
   assign nid_next = counter_ff + 32'd1;

   always_comb begin
      ex_wr       = 1'b0;
      ex_free_upd = 1'b0;
      ex_free_val = 1'b0;
      ex_slot     = slot;
      ex_status   = htm_pkg::ST_ERR;
      ex_nid      = '0;
      ex_sidx     = '0;
      case (req_type_ff)
         htm_pkg::REQ_ACTIVATE: begin
            if (!found) begin
               ex_status = htm_pkg::ST_FULL;
            end else if (!slot.lock) begin
               // new id may land on the marker: slot then still reads free
               ex_wr        = 1'b1;
               ex_slot.lock = 1'b0;
               ex_slot.id   = nid_next;
               ex_free_upd  = 1'b1;
               ex_free_val  = (nid_next == marker_ff);
               ex_status    = htm_pkg::ST_OK;
               ex_nid       = nid_next;
               ex_sidx      = htm_pkg::INDEX_W'(addr_ff);
            end
         end
         htm_pkg::REQ_INVALIDATE: begin
            if (match && !slot.lock) begin
               ex_wr       = 1'b1;
               ex_slot.id  = marker_ff;
               ex_free_upd = 1'b1;
               ex_free_val = 1'b1;
               ex_status   = htm_pkg::ST_OK;
            end
         end
         htm_pkg::REQ_VALIDATE: begin
            if (match) begin
               ex_status = htm_pkg::ST_OK;
            end
         end
         htm_pkg::REQ_ACQUIRE: begin
            if (match && !slot.lock) begin
               ex_wr        = 1'b1;
               ex_slot.lock = 1'b1;
               ex_status    = htm_pkg::ST_OK;
            end
         end
         htm_pkg::REQ_RELEASE: begin
            if (match) begin
               ex_wr        = 1'b1;
               ex_slot.lock = 1'b0;
               ex_status    = htm_pkg::ST_OK;
            end
         end
         default: begin
            ex_status = htm_pkg::ST_ERR;
         end
      endcase
   end

   // memory ports
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = ex_slot;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cnt_ff[ADDR_W-1:0];
      case (state_ff)
         S_CLEAR: begin
            mem_wr_en        = 1'b1;
            mem_wr_addr      = cnt_ff[ADDR_W-1:0];
            mem_wr_data.lock = 1'b0;
            mem_wr_data.id   = htm_pkg::EMPTY_MARKER_RST;
         end
         S_RSCAN: begin
            mem_rd_en = (cnt_ff != CNT_W'(TABLE_SLOTS));
         end
         S_FIND: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = (req_type_ff == htm_pkg::REQ_ACTIVATE) ? pick
                                                                 : idx_ff[ADDR_W-1:0];
         end
         S_EXEC: begin
            mem_wr_en = exec_fire && ex_wr;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // free flag updates
   always_comb begin
      upd_en   = 1'b0;
      upd_addr = addr_ff;
      upd_val  = ex_free_val;
      case (state_ff)
         S_CLEAR: begin
            upd_en   = 1'b1;
            upd_addr = cnt_ff[ADDR_W-1:0];
            upd_val  = (marker_ff == htm_pkg::EMPTY_MARKER_RST);
         end
         S_RSCAN: begin
            // registered read data belongs to the address one below cnt_ff
            upd_en   = (cnt_ff != '0);
            upd_addr = ADDR_W'(cnt_ff - CNT_W'(1));
            upd_val  = (slot.id == marker_ff);
         end
         S_EXEC: begin
            upd_en = exec_fire && ex_free_upd;
         end
         default: begin
            upd_en = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rescan_in = rescan_ff;
      case (state_ff)
         S_CLEAR: begin
            if (cnt_ff == CNT_W'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_RSCAN: begin
            if (cnt_ff == CNT_W'(TABLE_SLOTS)) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_IDLE: begin
            if (rescan_ff) begin
               state_in  = S_RSCAN;
               cnt_in    = '0;
               rescan_in = 1'b0;
            end else if (req_fire) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a marker change always earns a fresh rescan
      if (csr_fire && (csr_index == htm_pkg::CSR_EMPTY_MARKER)) begin
         rescan_in = 1'b1;
      end
   end

   always_comb begin
      counter_in = counter_ff;
      marker_in  = marker_ff;
      if (csr_fire && (csr_index == htm_pkg::CSR_ID_START)) begin
         counter_in = csr_data;
      end else if (exec_fire && (req_type_ff == htm_pkg::REQ_ACTIVATE) && ex_wr) begin
         counter_in = nid_next;
      end
      if (csr_fire && (csr_index == htm_pkg::CSR_EMPTY_MARKER)) begin
         marker_in = csr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rescan_ff    <= 1'b0;
         counter_ff   <= htm_pkg::ID_START_RST;
         marker_ff    <= htm_pkg::EMPTY_MARKER_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rescan_ff    <= rescan_in;
         counter_ff   <= counter_in;
         marker_ff    <= marker_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_type_ff <= req_tdata[2:0];
         idx_ff      <= req_tdata[18:3];
         hid_ff      <= req_tdata[50:19];
      end
      if (state_ff == S_FIND) begin
         addr_ff <= mem_rd_addr;
      end
      if (exec_fire) begin
         rsp_data_ff <= {6'd0, ex_sidx, ex_nid, ex_status};
      end
   end

endmodule

FILE: tb/tb_handle_table_manager.sv
// testbench for the handle table manager: directed and random request items
// checked against a slot-table predictor; depends on htm_pkg and handle_table_manager
`timescale 1ns / 100ps

typedef logic [htm_pkg::REQ_DATA_W-1:0] req_word_type;

typedef struct {
   logic [htm_pkg::STATUS_W-1:0] status;
   logic [htm_pkg::ID_W-1:0]     new_id;
   logic [htm_pkg::INDEX_W-1:0]  slot_index;
} handle_result_type;

// mirror of the slot table plus the queue of results still to come
class handle_scoreboard_type;
   logic [htm_pkg::ID_W-1:0] slot_id [htm_pkg::TABLE_SLOTS_DEF];
   bit                       slot_lock [htm_pkg::TABLE_SLOTS_DEF];
   logic [htm_pkg::ID_W-1:0] id_counter;
   logic [htm_pkg::ID_W-1:0] empty_marker;
   handle_result_type        expected_q [$];
   int                       errors;
   int                       checked;
   int                       ok_count;
   int                       err_count;
   int                       full_count;

   function new();
      empty_marker = htm_pkg::EMPTY_MARKER_RST;
      id_counter   = htm_pkg::ID_START_RST;
      for (int i = 0; i < htm_pkg::TABLE_SLOTS_DEF; i++) begin
         slot_id[i]   = htm_pkg::EMPTY_MARKER_RST;
         slot_lock[i] = 1'b0;
      end
   endfunction

   function void write_reg(input logic index, input logic [htm_pkg::ID_W-1:0] value);
      if (index == htm_pkg::CSR_ID_START) begin
         id_counter = value;
      end else begin
         // stored ids stay as they are
         empty_marker = value;
      end
   endfunction

   function void note_request(input logic [htm_pkg::REQ_W-1:0]   kind,
                              input logic [htm_pkg::INDEX_W-1:0] index,
                              input logic [htm_pkg::ID_W-1:0]    hid);
      handle_result_type r;
      bit                hit;
      int                pick;
      int                s;
      r.status     = htm_pkg::ST_ERR;
      r.new_id     = '0;
      r.slot_index = '0;
      s            = int'(index);
      hit          = 1'b0;
      if (s < htm_pkg::TABLE_SLOTS_DEF) hit = (slot_id[s] == hid);
      case (kind)
         htm_pkg::REQ_ACTIVATE: begin
            pick = -1;
            for (int i = 0; i < htm_pkg::TABLE_SLOTS_DEF; i++)
               if (pick < 0 && slot_id[i] == empty_marker) pick = i;
            if (pick < 0) begin
               r.status = htm_pkg::ST_FULL;
            end else if (!slot_lock[pick]) begin
               id_counter    = id_counter + 1'b1;
               slot_id[pick] = id_counter;
               r.status      = htm_pkg::ST_OK;
               r.new_id      = id_counter;
               r.slot_index  = htm_pkg::INDEX_W'(pick);
            end
         end
         htm_pkg::REQ_INVALIDATE: begin
            if (hit && !slot_lock[s]) begin
               slot_id[s] = empty_marker;
               r.status   = htm_pkg::ST_OK;
            end
         end
         htm_pkg::REQ_VALIDATE: begin
            if (hit) r.status = htm_pkg::ST_OK;
         end
         htm_pkg::REQ_ACQUIRE: begin
            if (hit && !slot_lock[s]) begin
               slot_lock[s] = 1'b1;
               r.status     = htm_pkg::ST_OK;
            end
         end
         htm_pkg::REQ_RELEASE: begin
            if (hit) begin
               slot_lock[s] = 1'b0;
               r.status     = htm_pkg::ST_OK;
            end
         end
         default: ;
      endcase
      expected_q.push_back(r);
   endfunction

   function void check_result(input logic [htm_pkg::RSP_DATA_W-1:0] data);
      handle_result_type got;
      handle_result_type want;
      got.status     = data[htm_pkg::STATUS_W-1:0];
      got.new_id     = data[htm_pkg::STATUS_W +: htm_pkg::ID_W];
      got.slot_index = data[htm_pkg::STATUS_W+htm_pkg::ID_W +: htm_pkg::INDEX_W];
      if (expected_q.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("result item with nothing expected: status %0d id %h slot %0d",
                     got.status, got.new_id, got.slot_index);
         return;
      end
      want = expected_q.pop_front();
      checked++;
      case (want.status)
         htm_pkg::ST_OK:   ok_count++;
         htm_pkg::ST_FULL: full_count++;
         default:          err_count++;
      endcase
      if (got.status !== want.status || got.new_id !== want.new_id ||
          got.slot_index !== want.slot_index) begin
         errors++;
         if (errors <= 10)
            $display("result %0d mismatch: status %0d/%0d id %h/%h slot %0d/%0d (exp/got)",
                     checked, want.status, got.status, want.new_id, got.new_id,
                     want.slot_index, got.slot_index);
      end
   endfunction
endclass

module tb_handle_table_manager;

   localparam int SLOTS = htm_pkg::TABLE_SLOTS_DEF;
   // margin after the last expected result has come back
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES = 5;
   localparam int PHASE_ITEMS = 90;
   // first and last request codes the block does not know
   localparam logic [htm_pkg::REQ_W-1:0] REQ_UNUSED_FIRST = htm_pkg::REQ_RELEASE + 3'd1;
   localparam logic [htm_pkg::REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   // req_type [2:0], handle_index [18:3], handle_id [50:19], zero [55:51]
   logic [htm_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   // status [1:0], new_id [33:2], slot_index [49:34], zero [55:50]
   logic [htm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid;
   logic                           csr_ready;
   logic                           csr_index;
   logic [htm_pkg::ID_W-1:0]       csr_data;

   handle_scoreboard_type board = new();

   // sender and receiver each switch between idling and full-rate stretches
   bit send_quiet;
   bit rsp_quiet;
   int stall_left;
   int items_sent;
   int activates_sent;

   handle_table_manager dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #2000000;
      $display("tb_handle_table_manager: FAIL");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 2);
      else if (r < 90) return $urandom_range(3, 6);
      else return $urandom_range(15, 40);
   endfunction

   // a random occupied slot, or any slot when the table is empty
   function automatic int pick_live_slot();
      int start;
      int s;
      start = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
         s = (start + k) % SLOTS;
         if (board.slot_id[s] != board.empty_marker) return s;
      end
      return start;
   endfunction

   // result side: check every accepted item, stall tready at random
   initial begin
      rsp_tready <= 1'b0;
      stall_left = 0;
      rsp_quiet  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if ($urandom_range(0, 199) == 0) rsp_quiet = !rsp_quiet;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!rsp_quiet && $urandom_range(0, 4) == 0) stall_left = pick_gap();
         end
      end
   end

   // drive one request item; valid stays high on return so that a back-to-back
   // item needs no second assignment in the same step
   task automatic send_req(input logic [htm_pkg::REQ_W-1:0]   kind,
                           input logic [htm_pkg::INDEX_W-1:0] index,
                           input logic [htm_pkg::ID_W-1:0]    hid);
      int gap;
      gap = 0;
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      if (!send_quiet && $urandom_range(0, 2) == 0) gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= req_word_type'({hid, index, kind});
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, index, hid);
      items_sent++;
      if (kind == htm_pkg::REQ_ACTIVATE) activates_sent++;
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [htm_pkg::ID_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one random item; handles mostly come from live slots so that the table
   // really fills, locks and drains
   task automatic send_random(input int act_pct);
      logic [htm_pkg::REQ_W-1:0]   kind;
      logic [htm_pkg::INDEX_W-1:0] index;
      logic [htm_pkg::ID_W-1:0]    hid;
      int                          r;
      int                          s;
      r = $urandom_range(0, 99);
      if (r < act_pct) begin
         kind = htm_pkg::REQ_ACTIVATE;
      end else if (r >= 96) begin
         kind = REQ_UNUSED_FIRST + htm_pkg::REQ_W'($urandom_range(0, 2));
      end else begin
         case ($urandom_range(0, 3))
            0:       kind = htm_pkg::REQ_INVALIDATE;
            1:       kind = htm_pkg::REQ_VALIDATE;
            2:       kind = htm_pkg::REQ_ACQUIRE;
            default: kind = htm_pkg::REQ_RELEASE;
         endcase
      end
      // junk fields for activate and unknown codes
      index = htm_pkg::INDEX_W'($urandom);
      hid   = $urandom;
      if (kind != htm_pkg::REQ_ACTIVATE && kind <= htm_pkg::REQ_RELEASE) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            s     = pick_live_slot();
            index = htm_pkg::INDEX_W'(s);
            hid   = board.slot_id[s];
         end else if (r < 80) begin
            // may hit a free slot through the empty marker
            s     = $urandom_range(0, SLOTS - 1);
            index = htm_pkg::INDEX_W'(s);
            hid   = board.slot_id[s];
         end else if (r < 90) begin
            // stale or corrupted id
            s     = $urandom_range(0, SLOTS - 1);
            index = htm_pkg::INDEX_W'(s);
            hid   = board.slot_id[s] ^ (32'd1 << $urandom_range(0, htm_pkg::ID_W - 1));
         end else begin
            index = htm_pkg::INDEX_W'($urandom_range(SLOTS, 65535));
         end
      end
      send_req(kind, index, hid);
   endtask

   // register settings per phase, extremes included
   task automatic apply_setting(input int phase);
      case (phase)
         1: begin
            // counter runs through all ones and wraps onto the marker
            write_csr(htm_pkg::CSR_ID_START, 32'hFFFF_FFF0);
            write_csr(htm_pkg::CSR_EMPTY_MARKER, 32'h0000_0000);
         end
         2: begin
            // old free slots now hold a live id of zero
            write_csr(htm_pkg::CSR_ID_START, $urandom);
            write_csr(htm_pkg::CSR_EMPTY_MARKER, 32'hFFFF_FFFF);
         end
         3: begin
            write_csr(htm_pkg::CSR_ID_START, 32'h0000_0000);
            write_csr(htm_pkg::CSR_EMPTY_MARKER, $urandom);
         end
         default: begin
            write_csr(htm_pkg::CSR_ID_START, 32'hFFFF_FFFF);
            write_csr(htm_pkg::CSR_EMPTY_MARKER, 32'h0000_0000);
         end
      endcase
   endtask

   function automatic int activate_share(input int phase);
      case (phase)
         0:       return 50;
         1:       return 85;  // drives the table to full
         2:       return 40;
         3:       return 60;
         default: return 35;
      endcase
   endfunction

   // directed items from reset values: first id issued is 2 in slot 0
   task automatic run_directed();
      send_req(htm_pkg::REQ_VALIDATE,   16'd0,    32'h0);          // free slot matches marker
      send_req(htm_pkg::REQ_VALIDATE,   16'd63,   32'h0);          // top slot, free
      send_req(htm_pkg::REQ_ACTIVATE,   16'd0,    32'h0);
      send_req(htm_pkg::REQ_VALIDATE,   16'd0,    32'd2);
      send_req(htm_pkg::REQ_VALIDATE,   16'd0,    32'd3);          // wrong id
      send_req(htm_pkg::REQ_VALIDATE,   16'hFFFF, 32'h0);          // index far out of range
      send_req(htm_pkg::REQ_RELEASE,    16'd64,   32'h0);          // first index out of range
      send_req(htm_pkg::REQ_ACQUIRE,    16'd0,    32'd2);
      send_req(htm_pkg::REQ_ACQUIRE,    16'd0,    32'd2);          // already locked
      send_req(htm_pkg::REQ_INVALIDATE, 16'd0,    32'd2);          // locked slot
      send_req(htm_pkg::REQ_RELEASE,    16'd0,    32'd2);
      send_req(htm_pkg::REQ_RELEASE,    16'd0,    32'd2);          // release while unlocked
      send_req(htm_pkg::REQ_INVALIDATE, 16'd0,    32'd2);
      send_req(htm_pkg::REQ_ACQUIRE,    16'd0,    32'h0);          // lock a free slot
      send_req(htm_pkg::REQ_ACTIVATE,   16'd0,    32'h0);          // lowest free slot locked
      send_req(htm_pkg::REQ_RELEASE,    16'd0,    32'h0);
      send_req(REQ_UNUSED_LAST,         16'hFFFF, 32'hFFFF_FFFF);  // unknown code, all ones
      send_req(REQ_UNUSED_FIRST,        16'd0,    32'h0);          // unknown code
      send_req(htm_pkg::REQ_ACTIVATE,   16'hFFFF, 32'hFFFF_FFFF);  // junk fields ignored
      send_req(htm_pkg::REQ_VALIDATE,   16'd0,    32'hFFFF_FFFF);
      send_req(htm_pkg::REQ_ACTIVATE,   16'hAAAA, 32'h5555_5555);
      send_req(htm_pkg::REQ_INVALIDATE, 16'd0,    32'd3);
      send_req(htm_pkg::REQ_INVALIDATE, 16'd1,    32'd4);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= htm_pkg::CSR_ID_START;
      csr_data   <= '0;
      send_quiet = 1'b0;
      items_sent = 0;
      activates_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // the block clears its table after reset; send_req waits on tready
      run_directed();
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_idle();
            apply_setting(phase);
         end
         repeat (PHASE_ITEMS) send_random(activate_share(phase));
      end
      wait_idle();

      $display("ran %0d items (%0d activates) over %0d register settings",
               items_sent, activates_sent, PHASES);
      $display("checked %0d results: %0d ok, %0d handle error, %0d no space",
               board.checked, board.ok_count, board.err_count, board.full_count);
      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("tb_handle_table_manager: PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", board.errors,
                  board.expected_q.size());
         $display("tb_handle_table_manager: FAIL");
      end
      $finish;
   end

endmodule
